// ----- hw/rtl/slri_pkg.sv -----
// Shared types and codes for the sorted list insert/remove block.
// Holds the item structs, status and operation codes, and the cell link types.
`default_nettype none

package slri_pkg;

   // Operation codes of an input item
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes of a result item
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   typedef struct packed {
      logic              operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         entry_count;
      logic [4:0]         removed_count;
      logic signed [31:0] smallest_value;
   } rsp_type;

   // Command broadcast to every cell in a cycle
   typedef struct packed {
      logic               insert_en;
      logic               remove_en;
      logic signed [31:0] value;
   } cell_cmd_type;

   // What a cell shows to its neighbors
   typedef struct packed {
      logic signed [31:0] entry;
      logic               occ;
      logic               gt;
   } cell_link_type;

endpackage

`default_nettype wire

// ----- hw/rtl/slri_cell.sv -----
// One storage cell of the sorted chain: holds one entry and its occupied bit.
// Depends on slri_pkg for the command and neighbor link types.
`default_nettype none

module slri_cell import slri_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_cmd_type  cmd,
   input  wire cell_link_type left_link,
   input  wire cell_link_type right_link,
   output      cell_link_type self_link,
   output      logic          match
);

   logic signed [31:0] entry_ff, entry_in;
   logic               occ_ff, occ_in;
   logic               gt, ge;

   // Compare own entry against the broadcast value
   always_comb begin
      gt    = occ_ff && (entry_ff > cmd.value);
      ge    = occ_ff && (entry_ff >= cmd.value);
      match = occ_ff && (entry_ff == cmd.value);
   end

   // Insert: shift right from the insertion point; remove: shift left over the run
   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (cmd.insert_en && (gt || (!occ_ff && left_link.occ))) begin
         entry_in = left_link.gt ? left_link.entry : cmd.value;
         occ_in   = 1'b1;
      end else if (cmd.remove_en && ge) begin
         entry_in = right_link.entry;
         occ_in   = right_link.occ;
      end
   end

   // Hold entry and occupied bit
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      entry_ff <= entry_in;
   end

   assign self_link = '{entry: entry_ff, occ: occ_ff, gt: gt};

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_list_insert_remove.sv -----
// Sorted multiset store built as a chain of compare-and-shift cells.
// An accepted item is registered into cmd_ff and runs in S_RUN; when it finishes, the result
// is registered into rsp_ff and rsp_valid rises. A remove runs until no equal entry is left
// (one equal entry leaves per cycle). A new item waits on req_stall until the running one
// finishes; a stalled result holds the running item until the result register frees.
// Reset empties the store at once through the per-cell occupied bits.
// Depends on slri_pkg and slri_cell.
`default_nettype none

module sorted_list_insert_remove import slri_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type     state_ff;
   req_type       cmd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   cell_cmd_type  cell_cmd;
   cell_link_type links [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] occ_vec;
   logic          any_match, full, slot_free, finish, do_insert;
   logic signed [31:0] min_after;
   logic [CNT_W+4:0] count_wide, removed_wide;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_l, right_l;
      if (i == 0) begin : g_head
         assign left_l = '{entry: '0, occ: 1'b1, gt: 1'b0};
      end else begin : g_mid_l
         assign left_l = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_l = '{entry: '0, occ: 1'b0, gt: 1'b0};
      end else begin : g_mid_r
         assign right_l = links[i+1];
      end
      slri_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .left_link  (left_l),
         .right_link (right_l),
         .self_link  (links[i]),
         .match      (match_vec[i])
      );
      assign occ_vec[i] = links[i].occ;
   end

   // Control decisions for the running item
   always_comb begin
      any_match = |match_vec;
      full      = (count_ff == CNT_W'(CAPACITY));
      slot_free = !rsp_valid_ff || !rsp_stall;
      do_insert = (state_ff == S_RUN) && (cmd_ff.operation == OP_INSERT)
                  && slot_free && !full;
      cell_cmd.value     = cmd_ff.value;
      cell_cmd.insert_en = do_insert;
      cell_cmd.remove_en = (state_ff == S_RUN) && (cmd_ff.operation == OP_REMOVE)
                           && any_match;
      if (state_ff != S_RUN) begin
         finish = 1'b0;
      end else if (cmd_ff.operation == OP_INSERT) begin
         finish = slot_free;
      end else begin
         finish = slot_free && !any_match;
      end
   end

   // Advance counts
   always_comb begin
      count_in   = count_ff;
      removed_in = removed_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cell_cmd.remove_en) begin
         count_in   = count_ff - CNT_W'(1);
         removed_in = removed_ff + CNT_W'(1);
      end
      if (req_valid && !req_stall) begin
         removed_in = '0;
      end
   end

   // Build the result item
   always_comb begin
      if (do_insert && (!links[0].occ || (cmd_ff.value < links[0].entry))) begin
         min_after = cmd_ff.value;
      end else if (links[0].occ) begin
         min_after = links[0].entry;
      end else begin
         min_after = '0;
      end
      count_wide   = {5'b0, count_in};
      removed_wide = {5'b0, removed_ff};
      rsp_in.entry_count    = count_wide[4:0];
      rsp_in.smallest_value = min_after;
      if (cmd_ff.operation == OP_INSERT) begin
         rsp_in.status        = full ? ST_FULL : ST_DONE;
         rsp_in.removed_count = '0;
      end else begin
         rsp_in.status        = (removed_ff == '0) ? ST_NOMATCH : ST_DONE;
         rsp_in.removed_count = removed_wide[4:0];
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      removed_ff <= removed_in;
      if (req_valid && !req_stall) begin
         cmd_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Entry count tracks the occupied bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(occ_vec))
      else $error("entry count out of step with occupied cells");

   // Occupied cells form a contiguous run from the head
   a_contig: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec + CAPACITY'(1)) & occ_vec) == '0)
      else $error("occupied cells not contiguous");

   // A remove with no match deletes nothing
   a_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NOMATCH) |-> rsp_data.removed_count == '0)
      else $error("no-match result reports removed entries");

endmodule

`default_nettype wire
